FILE: rtl/aes_pkg.sv
// Package with AES constants, S-box tables and round helper functions.
package aes_pkg;

    localparam int unsigned RK_DEPTH = 60;
    localparam int unsigned RK_ROWS  = RK_DEPTH / 4;

    localparam logic [2:0] REG_MODE = 3'd0;
    localparam logic [2:0] REG_KEY0 = 3'd1;
    localparam logic [2:0] REG_KEY1 = 3'd2;
    localparam logic [2:0] REG_KEY2 = 3'd3;
    localparam logic [2:0] REG_KEY3 = 3'd4;

    localparam logic [1:0] KS_128 = 2'd0;
    localparam logic [1:0] KS_192 = 2'd1;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] INV_SBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    function automatic logic [7:0] xt(input logic [7:0] a);
        xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] subst_word(input logic [31:0] w);
        subst_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    function automatic logic [31:0] mix_col(input logic [31:0] c);
        logic [7:0] a0, a1, a2, a3;
        a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
        mix_col = {xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3,
                   a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3,
                   a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3,
                   xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3)};
    endfunction

    function automatic logic [31:0] inv_mix_col(input logic [31:0] c);
        logic [7:0] a0, a1, a2, a3, u, v;
        // Precondition the column so that the forward mix gives the inverse mix.
        a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
        u = xt(xt(a0 ^ a2));
        v = xt(xt(a1 ^ a3));
        inv_mix_col = mix_col({a0 ^ u, a1 ^ v, a2 ^ u, a3 ^ v});
    endfunction

endpackage

FILE: rtl/aes_round.sv
// Combinational AES round unit shared by all rounds of both directions.
module aes_round
    import aes_pkg::*;
(
    input  logic [127:0] i_state,
    input  logic [127:0] i_key,
    input  logic         i_dec,
    input  logic         i_last,
    output logic [127:0] o_state
);

    logic [7:0]   s_in [16];
    logic [7:0]   s_sh [16];
    logic [127:0] sub_sh;
    logic [127:0] mixed;
    logic [127:0] keyed;

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            s_in[i] = i_state[127 - 8*i -: 8];
        end
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                if (i_dec) begin
                    s_sh[4*((c + r) % 4) + r] = INV_SBOX[s_in[4*c + r]];
                end else begin
                    s_sh[4*c + r] = SBOX[s_in[4*((c + r) % 4) + r]];
                end
            end
        end
        for (int i = 0; i < 16; i++) begin
            sub_sh[127 - 8*i -: 8] = s_sh[i];
        end
        keyed = sub_sh ^ i_key;
        for (int c = 0; c < 4; c++) begin
            if (i_dec) begin
                mixed[127 - 32*c -: 32] = inv_mix_col(keyed[127 - 32*c -: 32]);
            end else begin
                mixed[127 - 32*c -: 32] = mix_col(sub_sh[127 - 32*c -: 32]) ^
                                          i_key[127 - 32*c -: 32];
            end
        end
        o_state = i_last ? keyed : mixed;
    end

endmodule

FILE: rtl/aes_block_cipher.sv
// Top level of the AES block cipher with key expansion and round sequencer.
// A block is accepted only while the cipher is idle and no configuration write is offered.
// The first round key (the last one when decrypting) is added as the block is captured,
// then one shared round unit runs one round per cycle through the Nr rounds (10, 12 or
// 14 for 128, 192 or 256-bit keys). The result is held until it is taken, and a new block
// is only accepted after that, once the cipher is back in idle. Each round key is one row
// of the round-key store. A write to the key-size or a key register starts an expansion
// that fills the store one word per cycle (44, 52 or 60 words); no transaction is taken
// meanwhile. Writes to other indexes are ignored. Blocks must follow the first key write.
module aes_block_cipher
    import aes_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [2:0]   i_cfg_index,
    input  logic [63:0]  i_cfg_data,
    input  logic         i_valid,
    output logic         o_ready,
    input  logic         i_req_type,
    input  logic [63:0]  i_block_high,
    input  logic [63:0]  i_block_low,
    output logic         o_valid,
    input  logic         i_ready,
    output logic [63:0]  o_result_high,
    output logic [63:0]  o_result_low
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_EXPAND = 4'b0010,
        ST_ROUND  = 4'b0100,
        ST_DONE   = 4'b1000
    } t_state;

    t_state        r_state, n_state;
    logic [1:0]    r_mode;
    logic [63:0]   r_key [4];
    logic [127:0]  r_rk  [RK_ROWS];
    logic [5:0]    r_idx;
    logic [3:0]    r_nk_cnt;
    logic [7:0]    r_rcon;
    logic [31:0]   r_prev;
    logic [3:0]    r_round;
    logic          r_dec;
    logic [127:0]  r_blk;

    logic [3:0]    nk, nr;
    logic [5:0]    total;
    logic [31:0]   key_w;
    logic [31:0]   xform_w;
    logic [31:0]   new_w;
    logic [5:0]    back_idx;
    logic [127:0]  back_row;
    logic [31:0]   back_w;
    logic [3:0]    key_round;
    logic [127:0]  round_key;
    logic [127:0]  round_out;
    logic          cfg_fire;
    logic          in_fire;

    assign nk    = (r_mode == KS_128) ? 4'd4 : ((r_mode == KS_192) ? 4'd6 : 4'd8);
    assign nr    = nk + 4'd6;
    assign total = {nr, 2'b00} + 6'd4;

    assign o_cfg_ready = r_state[0];
    assign o_ready     = r_state[0] && !i_cfg_valid;
    assign o_valid     = r_state[3];
    assign cfg_fire    = i_cfg_valid && o_cfg_ready;
    assign in_fire     = i_valid && o_ready;
    assign o_result_high = r_blk[127:64];
    assign o_result_low  = r_blk[63:0];

    always_comb begin
        key_w    = r_idx[0] ? r_key[r_idx[2:1]][31:0] : r_key[r_idx[2:1]][63:32];
        back_idx = r_idx - {2'b00, nk};
        back_row = r_rk[back_idx[5:2]];
        case (back_idx[1:0])
            2'd0:    back_w = back_row[127:96];
            2'd1:    back_w = back_row[95:64];
            2'd2:    back_w = back_row[63:32];
            default: back_w = back_row[31:0];
        endcase
        xform_w  = r_prev;
        if (r_nk_cnt == 4'd0) begin
            xform_w = subst_word({r_prev[23:0], r_prev[31:24]}) ^ {r_rcon, 24'h0};
        end else if (nk == 4'd8 && r_nk_cnt == 4'd4) begin
            xform_w = subst_word(r_prev);
        end
        new_w = (r_idx < {2'b00, nk}) ? key_w : (back_w ^ xform_w);
    end

    always_comb begin
        key_round = r_dec ? (nr - r_round) : r_round;
        round_key = r_rk[key_round];
    end

    aes_round u_round (
        .i_state (r_blk),
        .i_key   (round_key),
        .i_dec   (r_dec),
        .i_last  (r_round == nr),
        .o_state (round_out)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (cfg_fire) begin
                    n_state = (i_cfg_index <= REG_KEY3) ? ST_EXPAND : ST_IDLE;
                end else if (in_fire) begin
                    n_state = ST_ROUND;
                end
            end
            ST_EXPAND: if (r_idx == total - 6'd1) n_state = ST_IDLE;
            ST_ROUND:  if (r_round == nr) n_state = ST_DONE;
            ST_DONE:   if (i_ready) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_mode  <= KS_128;
            for (int i = 0; i < 4; i++) r_key[i] <= 64'h0;
        end else begin
            r_state <= n_state;
            if (cfg_fire) begin
                case (i_cfg_index)
                    REG_MODE: r_mode <= i_cfg_data[1:0];
                    REG_KEY0: r_key[0] <= i_cfg_data;
                    REG_KEY1: r_key[1] <= i_cfg_data;
                    REG_KEY2: r_key[2] <= i_cfg_data;
                    REG_KEY3: r_key[3] <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE) begin
            r_idx    <= 6'd0;
            r_nk_cnt <= 4'd0;
            r_rcon   <= 8'h01;
        end else if (r_state == ST_EXPAND) begin
            case (r_idx[1:0])
                2'd0:    r_rk[r_idx[5:2]][127:96] <= new_w;
                2'd1:    r_rk[r_idx[5:2]][95:64]  <= new_w;
                2'd2:    r_rk[r_idx[5:2]][63:32]  <= new_w;
                default: r_rk[r_idx[5:2]][31:0]   <= new_w;
            endcase
            r_prev      <= new_w;
            r_idx       <= r_idx + 6'd1;
            if (r_nk_cnt == nk - 4'd1) begin
                r_nk_cnt <= 4'd0;
            end else begin
                r_nk_cnt <= r_nk_cnt + 4'd1;
            end
            if (r_nk_cnt == 4'd0 && r_idx >= {2'b00, nk}) begin
                r_rcon <= xt(r_rcon);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_dec   <= i_req_type;
            r_round <= 4'd1;
            r_blk   <= {i_block_high, i_block_low} ^ (i_req_type ? r_rk[nr] : r_rk[0]);
        end else if (r_state == ST_ROUND) begin
            r_blk   <= round_out;
            r_round <= r_round + 4'd1;
        end
    end

endmodule

FILE: rtl/aes_checker.sv
// Port-level checker for the AES block cipher, bound to the top level.
module aes_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_cfg_valid,
    input logic        o_cfg_ready,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [63:0] o_result_high,
    input logic [63:0] o_result_low
);

    a_no_ready_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready && !o_cfg_ready)
        else $error("Block accepted while a result was pending.");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready && !o_valid)
        else $error("Block ready or done right after a transaction.");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> o_valid && $stable(o_result_high) && $stable(o_result_low))
        else $error("Result changed while stalled.");

    a_idle_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready) |=> o_cfg_ready)
        else $error("Block not idle after result transaction.");

endmodule

bind aes_block_cipher aes_checker u_aes_checker (.*);

FILE: bench/aes_block_cipher_tb.sv
// Self-checking testbench for the AES block cipher: known vectors, then random traffic.
module aes_block_cipher_tb;
    import aes_pkg::*;

    localparam logic [1:0] KS_256      = 2'd2;
    localparam logic [1:0] KS_256_ALT  = 2'd3;
    localparam logic [2:0] REG_UNUSED  = 3'd5;
    localparam logic       REQ_ENC     = 1'b0;
    localparam logic       REQ_DEC     = 1'b1;
    localparam int         CYCLE_LIMIT = 400000;
    localparam int         RAND_PHASES = 10;
    localparam int         PHASE_ITEMS = 50;

    typedef struct packed {
        logic [63:0] hi;
        logic [63:0] lo;
    } t_block;

    typedef struct {
        logic        set_key;
        logic [1:0]  mode;
        logic [63:0] key [4];
        logic        req;
        t_block      din;
        logic        known;
        t_block      dout;
    } t_vector;

    localparam logic [63:0] ONES = 64'hffff_ffff_ffff_ffff;
    localparam logic [63:0] KA = 64'h0001020304050607, KB = 64'h08090a0b0c0d0e0f;
    localparam logic [63:0] KC = 64'h1011121314151617, KD = 64'h18191a1b1c1d1e1f;
    localparam t_block PT = '{64'h0011223344556677, 64'h8899aabbccddeeff};
    localparam t_block ZB = '{64'h0, 64'h0};
    localparam t_block OB = '{ONES, ONES};
    localparam t_block CT_ZERO = '{64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e};
    localparam t_block CT128 = '{64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a};
    localparam t_block CT192 = '{64'hdda97ca4864cdfe0, 64'h6eaf70a0ec0d7191};
    localparam t_block CT256 = '{64'h8ea2b7ca516745bf, 64'heafc49904b496089};

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [63:0] i_cfg_data;
    logic        i_valid;
    logic        o_ready;
    logic        i_req_type;
    logic [63:0] i_block_high;
    logic [63:0] i_block_low;
    logic        o_valid;
    logic        i_ready;
    logic [63:0] o_result_high;
    logic [63:0] o_result_low;

    aes_block_cipher u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_ready(o_ready), .i_req_type(i_req_type),
        .i_block_high(i_block_high), .i_block_low(i_block_low),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_result_high(o_result_high), .o_result_low(o_result_low)
    );

    logic [7:0]  sub_tab [256];
    logic [7:0]  inv_tab [256];
    logic [1:0]  key_mode;
    logic [63:0] key_regs [4];
    logic [31:0] sched [60];
    t_block      pending_blocks [$];
    int          mismatches;
    int          cycles;
    int          next_gap;
    bit          burst;

    t_vector vectors [18];

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [7:0] xtime(logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gmul(logic [7:0] a, logic [7:0] b);
        logic [7:0] p;
        p = 8'h00;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) p ^= a;
            a = xtime(a);
        end
        return p;
    endfunction

    function automatic logic [7:0] ginv(logic [7:0] x);
        logic [7:0] r;
        r = 8'h01;
        for (int i = 0; i < 254; i++) r = gmul(r, x);
        return r;
    endfunction

    function automatic logic [7:0] rotl8(logic [7:0] v, int n);
        return (v << n) | (v >> (8 - n));
    endfunction

    function automatic logic [31:0] subw(logic [31:0] w);
        return {sub_tab[w[31:24]], sub_tab[w[23:16]], sub_tab[w[15:8]], sub_tab[w[7:0]]};
    endfunction

    function automatic int key_words_for_mode();
        return (key_mode == KS_128) ? 4 : (key_mode == KS_192) ? 6 : 8;
    endfunction

    function automatic void expand_schedule();
        int          nk;
        logic [31:0] t;
        logic [7:0]  rc;
        nk = key_words_for_mode();
        rc = 8'h01;
        for (int i = 0; i < nk; i++)
            sched[i] = i[0] ? key_regs[i >> 1][31:0] : key_regs[i >> 1][63:32];
        for (int i = nk; i < 4 * (nk + 7); i++) begin
            t = sched[i - 1];
            if (i % nk == 0) begin
                t = subw({t[23:0], t[31:24]}) ^ {rc, 24'h0};
                rc = xtime(rc);
            end else if (nk > 6 && i % nk == 4) begin
                t = subw(t);
            end
            sched[i] = sched[i - nk] ^ t;
        end
    endfunction

    function automatic void apply_reg(logic [2:0] idx, logic [63:0] data);
        if (idx == REG_MODE) begin
            key_mode = data[1:0];
        end else if (idx <= REG_KEY3) begin
            key_regs[idx - 3'd1] = data;
        end else begin
            return;
        end
        expand_schedule();
    endfunction

    function automatic logic [127:0] key_mix(logic [127:0] v, int rnd);
        for (int c = 0; c < 4; c++) v[127 - 32 * c -: 32] ^= sched[(4 * rnd + c) % 60];
        return v;
    endfunction

    function automatic logic [127:0] sub_state(logic [127:0] v, bit inv);
        for (int i = 0; i < 16; i++)
            v[127 - 8 * i -: 8] = inv ? inv_tab[v[127 - 8 * i -: 8]] : sub_tab[v[127 - 8 * i -: 8]];
        return v;
    endfunction

    function automatic logic [127:0] shift_state(logic [127:0] v, bit inv);
        logic [127:0] t;
        int           src, dst;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                src = inv ? 4 * c + r : 4 * ((c + r) & 3) + r;
                dst = inv ? 4 * ((c + r) & 3) + r : 4 * c + r;
                t[127 - 8 * dst -: 8] = v[127 - 8 * src -: 8];
            end
        end
        return t;
    endfunction

    function automatic logic [127:0] mix_state(logic [127:0] v, bit inv);
        logic [7:0] coef [4];
        logic [7:0] a [4];
        logic [7:0] b;
        if (inv) begin
            coef[0] = 8'd14; coef[1] = 8'd11; coef[2] = 8'd13; coef[3] = 8'd9;
        end else begin
            coef[0] = 8'd2; coef[1] = 8'd3; coef[2] = 8'd1; coef[3] = 8'd1;
        end
        for (int c = 0; c < 4; c++) begin
            for (int k = 0; k < 4; k++) a[k] = v[127 - 8 * (4 * c + k) -: 8];
            for (int r = 0; r < 4; r++) begin
                b = 8'h00;
                for (int k = 0; k < 4; k++) b ^= gmul(coef[(k + 4 - r) & 3], a[k]);
                v[127 - 8 * (4 * c + r) -: 8] = b;
            end
        end
        return v;
    endfunction

    function automatic t_block cipher_block(logic dec, t_block din);
        logic [127:0] v;
        int           nr;
        v = din;
        nr = key_words_for_mode() + 6;
        if (dec == REQ_ENC) begin
            v = key_mix(v, 0);
            for (int rnd = 1; rnd < nr; rnd++)
                v = key_mix(mix_state(shift_state(sub_state(v, 0), 0), 0), rnd);
            v = key_mix(shift_state(sub_state(v, 0), 0), nr);
        end else begin
            v = key_mix(v, nr);
            for (int rnd = nr - 1; rnd > 0; rnd--)
                v = mix_state(key_mix(sub_state(shift_state(v, 1), 1), rnd), 1);
            v = key_mix(sub_state(shift_state(v, 1), 1), 0);
        end
        return v;
    endfunction

    function automatic int draw_gap();
        return burst ? 0 : $urandom_range(0, 5);
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [63:0] data);
        repeat (draw_gap()) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        apply_reg(idx, data);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic load_key(logic [1:0] mode, logic [63:0] k0, logic [63:0] k1,
                            logic [63:0] k2, logic [63:0] k3);
        write_reg(REG_MODE, {$urandom, $urandom} & ~64'h3 | {62'h0, mode});
        write_reg(REG_KEY0, k0);
        write_reg(REG_KEY1, k1);
        write_reg(REG_KEY2, k2);
        write_reg(REG_KEY3, k3);
        write_reg(3'($urandom_range(REG_UNUSED, 7)), {$urandom, $urandom});
    endtask

    task automatic send_block(logic req, t_block din, logic known, t_block dout);
        repeat (next_gap) @(posedge i_clk);
        i_valid      <= 1'b1;
        i_req_type   <= req;
        i_block_high <= din.hi;
        i_block_low  <= din.lo;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        pending_blocks.push_back(known ? dout : cipher_block(req, din));
        next_gap = draw_gap();
        if (next_gap != 0) i_valid <= 1'b0;
    endtask

    task automatic drain();
        if (next_gap == 0) begin
            i_valid <= 1'b0;
            next_gap = 1;
        end
        while (pending_blocks.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [63:0] rand_word();
        case ($urandom_range(0, 9))
            0: return 64'h0;
            1: return ONES;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    initial begin
        int w;
        i_ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            w = draw_gap();
            if (w != 0) begin
                i_ready <= 1'b0;
                repeat (w) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (!(o_valid && i_ready)) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_block got, want;
        if (i_rst_n && o_valid && i_ready) begin
            got = '{o_result_high, o_result_low};
            if (pending_blocks.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h %h", got.hi, got.lo);
            end else begin
                want = pending_blocks.pop_front();
                if (got.hi !== want.hi || got.lo !== want.lo) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected %h %h, actual %h %h",
                                 want.hi, want.lo, got.hi, got.lo);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("aes_block_cipher: mismatch");
            $finish;
        end
    end

    initial begin
        t_block din;
        int     items;
        vectors = '{
            '{1, KS_128, '{64'h0, 64'h0, 64'h0, 64'h0}, REQ_ENC, ZB, 1, CT_ZERO},
            '{0, KS_128, '{64'h0, 64'h0, 64'h0, 64'h0}, REQ_DEC, CT_ZERO, 1, ZB},
            '{0, KS_128, '{64'h0, 64'h0, 64'h0, 64'h0}, REQ_ENC, OB, 0, ZB},
            '{1, KS_128, '{KA, KB, ONES, ONES}, REQ_ENC, PT, 1, CT128},
            '{0, KS_128, '{KA, KB, ONES, ONES}, REQ_DEC, CT128, 1, PT},
            '{1, KS_128, '{ONES, ONES, 64'h0, 64'h0}, REQ_ENC, OB, 0, ZB},
            '{0, KS_128, '{ONES, ONES, 64'h0, 64'h0}, REQ_DEC, ZB, 0, ZB},
            '{1, KS_192, '{KA, KB, KC, ONES}, REQ_ENC, PT, 1, CT192},
            '{0, KS_192, '{KA, KB, KC, ONES}, REQ_DEC, CT192, 1, PT},
            '{1, KS_192, '{ONES, ONES, ONES, 64'h0}, REQ_DEC, OB, 0, ZB},
            '{1, KS_256, '{KA, KB, KC, KD}, REQ_ENC, PT, 1, CT256},
            '{0, KS_256, '{KA, KB, KC, KD}, REQ_DEC, CT256, 1, PT},
            '{1, KS_256_ALT, '{KA, KB, KC, KD}, REQ_ENC, PT, 1, CT256},
            '{0, KS_256_ALT, '{KA, KB, KC, KD}, REQ_DEC, CT256, 1, PT},
            '{1, KS_256, '{ONES, ONES, ONES, ONES}, REQ_ENC, ZB, 0, ZB},
            '{0, KS_256, '{ONES, ONES, ONES, ONES}, REQ_DEC, OB, 0, ZB},
            '{1, KS_256, '{64'h0, 64'h0, 64'h0, 64'h0}, REQ_ENC, OB, 0, ZB},
            '{0, KS_256, '{64'h0, 64'h0, 64'h0, 64'h0}, REQ_DEC, ZB, 0, ZB}
        };
        for (int i = 0; i < 256; i++) begin
            sub_tab[i] = ginv(8'(i));
            sub_tab[i] = sub_tab[i] ^ rotl8(sub_tab[i], 1) ^ rotl8(sub_tab[i], 2)
                       ^ rotl8(sub_tab[i], 3) ^ rotl8(sub_tab[i], 4) ^ 8'h63;
            inv_tab[i] = ginv(rotl8(8'(i), 1) ^ rotl8(8'(i), 3) ^ rotl8(8'(i), 6) ^ 8'h05);
        end
        key_mode = KS_128;
        key_regs = '{64'h0, 64'h0, 64'h0, 64'h0};
        mismatches = 0;
        cycles = 0;
        next_gap = 0;
        burst = 0;
        i_rst_n      <= 1'b0;
        i_cfg_valid  <= 1'b0;
        i_cfg_index  <= REG_MODE;
        i_cfg_data   <= 64'h0;
        i_valid      <= 1'b0;
        i_req_type   <= REQ_ENC;
        i_block_high <= 64'h0;
        i_block_low  <= 64'h0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (vectors[i]) begin
            if (vectors[i].set_key) begin
                drain();
                load_key(vectors[i].mode, vectors[i].key[0], vectors[i].key[1],
                         vectors[i].key[2], vectors[i].key[3]);
            end
            send_block(vectors[i].req, vectors[i].din, vectors[i].known, vectors[i].dout);
        end

        for (int p = 0; p < RAND_PHASES; p++) begin
            drain();
            burst = ($urandom_range(0, 3) == 0);
            if (p == 0 || $urandom_range(0, 2) == 0) begin
                load_key(2'($urandom_range(0, 3)), rand_word(), rand_word(),
                         rand_word(), rand_word());
            end else begin
                write_reg(REG_MODE, {$urandom, $urandom});
                for (int k = 0; k < 4; k++)
                    if ($urandom_range(0, 1)) write_reg(3'(REG_KEY0 + k), rand_word());
            end
            items = (p == 0) ? PHASE_ITEMS : $urandom_range(PHASE_ITEMS / 2, PHASE_ITEMS * 3 / 2);
            for (int n = 0; n < items; n++) begin
                din = '{rand_word(), rand_word()};
                send_block(1'($urandom_range(0, 1)), din, 0, din);
            end
        end

        drain();
        repeat (40) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("aes_block_cipher: match");
        end else begin
            $display("aes_block_cipher: mismatch");
        end
        $finish;
    end

endmodule
